### rtl/sbq_pkg.sv
// shared types and constants for the serial byte queues
`default_nettype none

package sbq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2048;
  localparam int unsigned BURST_LEN       = 16;
  localparam int unsigned CNT_W           = $clog2(BURST_LEN);
  localparam int unsigned FILL_W          = 12;
  localparam int unsigned BYTE_W          = 8;

  // input operation codes
  typedef enum logic [2:0] {
    OP_HOST_WRITE  = 3'd0,
    OP_HOST_READ   = 3'd1,
    OP_RX_BYTE     = 3'd2,
    OP_TX_READY    = 3'd3,
    OP_KICK        = 3'd4,
    OP_MODEM_STAT  = 3'd5,
    OP_LINE_STAT   = 3'd6
  } op_t;

  // result kinds
  typedef enum logic [2:0] {
    KIND_ACCEPTED  = 3'd0,
    KIND_READ_DATA = 3'd1,
    KIND_READ_EMPTY = 3'd2,
    KIND_TX_BYTE   = 3'd3,
    KIND_NOTHING   = 3'd4
  } kind_t;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } state_t;

  // one result beat
  typedef struct packed {
    logic              line_seen;
    logic [BYTE_W-1:0] lsr_byte;
    logic              modem_seen;
    logic [BYTE_W-1:0] msr_byte;
    logic [FILL_W-1:0] tx_fill;
    logic [FILL_W-1:0] rx_fill;
    logic              dropped;
    logic              last;
    logic [BYTE_W-1:0] data;
    kind_t             kind;
  } result_t;

endpackage

`default_nettype wire

### rtl/serial_tx_rx_byte_queues_top.sv
// Serial byte queues: host-side transmit and receive rings with status capture.
// An input beat is captured first; its result is loaded into the output register once
// that register is free. No new input beat is accepted until the operation is done; a
// transmit drain emits one byte per cycle from queue memory (up to 16) while not stalled.
// Reset (rst, synchronous): pointers, status bytes, seen flags and the mode bit clear;
// queue memories are not cleared and no clearing pass is needed.
`default_nettype none

module serial_tx_rx_byte_queues_top #(
  parameter int unsigned QUEUE_DEPTH = sbq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,      // uart_is_16550
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // byte_value[7:0]
  input  wire logic [2:0]  s_axis_tuser,   // op[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // data_out[7:0], dropped[8], rx_fill[20:9], tx_fill[32:21], modem_stat_out[40:33],
  // modem_seen[41], line_stat_out[49:42], line_seen[50], zero[55:51]
  output logic [55:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser,   // kind[2:0]
  output logic             m_axis_tlast    // last
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  sbq_pkg::result_t res;
  logic rx_we, tx_we;
  logic [AW-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;
  logic [sbq_pkg::BYTE_W-1:0] rx_wdata, rx_rdata, tx_wdata, tx_rdata;

  // receive queue storage
  sbq_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (rx_wdata),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  // transmit queue storage
  sbq_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  // sequencer
  sbq_ctrl #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (sbq_pkg::op_t'(s_axis_tuser)),
    .in_byte   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res),
    .rx_we     (rx_we),
    .rx_waddr  (rx_waddr),
    .rx_wdata  (rx_wdata),
    .rx_raddr  (rx_raddr),
    .rx_rdata  (rx_rdata),
    .tx_we     (tx_we),
    .tx_waddr  (tx_waddr),
    .tx_wdata  (tx_wdata),
    .tx_raddr  (tx_raddr),
    .tx_rdata  (tx_rdata)
  );

  // result beat packing
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {5'd0, res.line_seen, res.lsr_byte, res.modem_seen,
                         res.msr_byte, res.tx_fill, res.rx_fill, res.dropped,
                         res.data};

endmodule

`default_nettype wire

### rtl/sbq_ram.sv
// byte queue storage, one write port and one registered read port
`default_nettype none

module sbq_ram #(
  parameter int unsigned DEPTH = sbq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [sbq_pkg::BYTE_W-1:0] wdata,
  input  wire logic [AW-1:0]             raddr,
  output logic      [sbq_pkg::BYTE_W-1:0] rdata
);

  logic [sbq_pkg::BYTE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/sbq_ctrl.sv
// queue pointers, status capture, sequencer and output register
`default_nettype none

module sbq_ctrl #(
  parameter int unsigned DEPTH = sbq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire sbq_pkg::op_t               in_op,
  input  wire logic [sbq_pkg::BYTE_W-1:0] in_byte,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output sbq_pkg::result_t                out_res,
  output logic                            rx_we,
  output logic      [AW-1:0]              rx_waddr,
  output logic      [sbq_pkg::BYTE_W-1:0] rx_wdata,
  output logic      [AW-1:0]              rx_raddr,
  input  wire logic [sbq_pkg::BYTE_W-1:0] rx_rdata,
  output logic                            tx_we,
  output logic      [AW-1:0]              tx_waddr,
  output logic      [sbq_pkg::BYTE_W-1:0] tx_wdata,
  output logic      [AW-1:0]              tx_raddr,
  input  wire logic [sbq_pkg::BYTE_W-1:0] tx_rdata
);

  localparam int unsigned PW  = $clog2(2 * DEPTH);
  localparam int unsigned FXW = (PW > sbq_pkg::FILL_W) ? PW : sbq_pkg::FILL_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(2 * DEPTH - 1);
  localparam logic [PW:0]   PTR_SPAN = (PW + 1)'(2 * DEPTH);
  localparam logic [PW-1:0] DEPTH_P  = PW'(DEPTH);

  // pointer helpers, pointers run modulo twice the depth
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= DEPTH_P) ? p - DEPTH_P : p;
    ptr_slot = s[AW-1:0];
  endfunction

  function automatic logic [PW-1:0] fill_of(input logic [PW-1:0] w, input logic [PW-1:0] r);
    logic [PW:0] f;
    f = {1'b0, w} + ((w < r) ? PTR_SPAN : '0) - {1'b0, r};
    fill_of = f[PW-1:0];
  endfunction

  function automatic logic [sbq_pkg::FILL_W-1:0] fill_out(input logic [PW-1:0] f);
    logic [FXW-1:0] x;
    x = FXW'(f);
    fill_out = x[sbq_pkg::FILL_W-1:0];
  endfunction

  sbq_pkg::state_t state, state_next;

  logic [PW-1:0] rx_wr, rx_wr_next, rx_rd, rx_rd_next;
  logic [PW-1:0] tx_wr, tx_wr_next, tx_rd, tx_rd_next;
  logic [sbq_pkg::BYTE_W-1:0] msr_byte, msr_byte_next;
  logic [sbq_pkg::BYTE_W-1:0] lsr_byte, lsr_byte_next;
  logic modem_seen, modem_seen_next, line_seen, line_seen_next;
  logic [sbq_pkg::CNT_W-1:0] cnt, cnt_next, lim_m1;
  logic is_16550;
  sbq_pkg::op_t op;
  logic [sbq_pkg::BYTE_W-1:0] byte_val;

  logic out_free, load, done;
  logic [PW-1:0] rx_fill_now, tx_fill_now, tx_fill_after;
  sbq_pkg::result_t res;

  assign out_free    = !out_valid || out_ready;
  assign rx_fill_now = fill_of(rx_wr, rx_rd);
  assign tx_fill_now = fill_of(tx_wr, tx_rd);
  assign tx_fill_after = tx_fill_now - PW'(1);
  assign lim_m1 = (op == sbq_pkg::OP_TX_READY && is_16550) ?
                  sbq_pkg::CNT_W'(sbq_pkg::BURST_LEN - 1) : '0;

  // memory addresses, reads track the pointer being loaded
  assign rx_waddr = ptr_slot(rx_wr);
  assign tx_waddr = ptr_slot(tx_wr);
  assign rx_wdata = byte_val;
  assign tx_wdata = byte_val;
  assign rx_raddr = ptr_slot(rx_rd_next);
  assign tx_raddr = ptr_slot(tx_rd_next);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sbq_pkg::ST_IDLE: if (in_valid) state_next = sbq_pkg::ST_BUSY;
      sbq_pkg::ST_BUSY: if (done) state_next = sbq_pkg::ST_IDLE;
      default:          state_next = sbq_pkg::ST_IDLE;
    endcase
  end

  // per-operation datapath
  always_comb begin
    in_ready          = (state == sbq_pkg::ST_IDLE);
    load              = 1'b0;
    done              = 1'b0;
    rx_we             = 1'b0;
    tx_we             = 1'b0;
    rx_wr_next        = rx_wr;
    rx_rd_next        = rx_rd;
    tx_wr_next        = tx_wr;
    tx_rd_next        = tx_rd;
    cnt_next          = cnt;
    msr_byte_next     = msr_byte;
    modem_seen_next   = modem_seen;
    lsr_byte_next     = lsr_byte;
    line_seen_next    = line_seen;
    res               = '0;
    res.kind          = sbq_pkg::KIND_ACCEPTED;
    res.last          = 1'b1;
    if (state == sbq_pkg::ST_BUSY && out_free) begin
      load = 1'b1;
      done = 1'b1;
      case (op) inside
        sbq_pkg::OP_HOST_WRITE: begin
          if (tx_fill_now >= DEPTH_P) begin
            res.dropped = 1'b1;
          end else begin
            tx_we      = 1'b1;
            tx_wr_next = ptr_inc(tx_wr);
          end
        end
        sbq_pkg::OP_RX_BYTE: begin
          if (rx_fill_now >= DEPTH_P) begin
            res.dropped = 1'b1;
          end else begin
            rx_we      = 1'b1;
            rx_wr_next = ptr_inc(rx_wr);
          end
        end
        sbq_pkg::OP_HOST_READ: begin
          if (rx_fill_now == '0) begin
            res.kind = sbq_pkg::KIND_READ_EMPTY;
          end else begin
            res.kind   = sbq_pkg::KIND_READ_DATA;
            res.data   = rx_rdata;
            rx_rd_next = ptr_inc(rx_rd);
          end
        end
        sbq_pkg::OP_TX_READY, sbq_pkg::OP_KICK: begin
          if (tx_fill_now == '0) begin
            res.kind = sbq_pkg::KIND_NOTHING;
            cnt_next = '0;
          end else begin
            res.kind   = sbq_pkg::KIND_TX_BYTE;
            res.data   = tx_rdata;
            tx_rd_next = ptr_inc(tx_rd);
            res.last   = (cnt == lim_m1) || (tx_fill_after == '0);
            done       = res.last;
            cnt_next   = res.last ? '0 : cnt + sbq_pkg::CNT_W'(1);
          end
        end
        sbq_pkg::OP_MODEM_STAT: begin
          msr_byte_next   = byte_val;
          modem_seen_next = 1'b1;
        end
        sbq_pkg::OP_LINE_STAT: begin
          lsr_byte_next  = byte_val;
          line_seen_next = 1'b1;
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
    res.rx_fill    = fill_out(fill_of(rx_wr_next, rx_rd_next));
    res.tx_fill    = fill_out(fill_of(tx_wr_next, tx_rd_next));
    res.msr_byte   = msr_byte_next;
    res.modem_seen = modem_seen_next;
    res.lsr_byte   = lsr_byte_next;
    res.line_seen  = line_seen_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sbq_pkg::ST_IDLE;
      rx_wr        <= '0;
      rx_rd        <= '0;
      tx_wr        <= '0;
      tx_rd        <= '0;
      cnt          <= '0;
      msr_byte     <= '0;
      modem_seen   <= 1'b0;
      lsr_byte     <= '0;
      line_seen    <= 1'b0;
      is_16550     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      rx_wr        <= rx_wr_next;
      rx_rd        <= rx_rd_next;
      tx_wr        <= tx_wr_next;
      tx_rd        <= tx_rd_next;
      cnt          <= cnt_next;
      msr_byte     <= msr_byte_next;
      modem_seen   <= modem_seen_next;
      lsr_byte     <= lsr_byte_next;
      line_seen    <= line_seen_next;
      if (cfg_we) begin
        is_16550 <= cfg_wdata;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // input capture and result register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op       <= in_op;
      byte_val <= in_byte;
    end
    if (load) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

### dv/serial_tx_rx_byte_queues_top_tb.sv
// self-checking testbench for the serial transmit/receive byte queues
`timescale 1ns / 1ps

module serial_tx_rx_byte_queues_top_tb;
  import sbq_pkg::*;

  localparam int unsigned DEPTH          = QUEUE_DEPTH_DEF;
  localparam int unsigned SLOT_W         = $clog2(DEPTH);
  localparam int unsigned RST_CYCLES     = 7;
  localparam int unsigned SETTLE_CYC     = 8;
  localparam int unsigned TAIL_CYC       = 40;
  localparam int unsigned END_WAIT       = 20000;
  localparam int unsigned CYCLE_LIMIT    = 1000000;
  localparam int unsigned RAND_PER_PHASE = 40;
  localparam int unsigned MAX_REPORTS    = 100;
  // op code 7 has no meaning; the block must swallow it
  localparam logic [2:0]  OP_UNUSED      = 3'd7;

  // one expected result beat
  typedef struct {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              dropped;
    logic [FILL_W-1:0] rx_fill;
    logic [FILL_W-1:0] tx_fill;
    logic [BYTE_W-1:0] modem;
    logic              modem_seen;
    logic [BYTE_W-1:0] line;
    logic              line_seen;
  } uart_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // byte_value[7:0]
  logic [2:0]  s_axis_tuser = 3'd0;    // op[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // data_out[7:0], dropped[8], rx_fill[20:9], tx_fill[32:21], modem_stat_out[40:33],
  // modem_seen[41], line_stat_out[49:42], line_seen[50], zero[55:51]
  logic [55:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;           // kind[2:0]
  logic        m_axis_tlast;           // last

  // shadow copy of the queues, status bytes and mode
  logic [BYTE_W-1:0] rx_mem [DEPTH];
  logic [BYTE_W-1:0] tx_mem [DEPTH];
  logic [FILL_W-1:0] rx_wr = '0, rx_rd = '0, tx_wr = '0, tx_rd = '0;
  logic [BYTE_W-1:0] modem_reg = '0, line_reg = '0;
  logic              modem_seen = 1'b0, line_seen = 1'b0;
  logic              burst_mode = 1'b0;

  uart_beat_t  pending_beats [$];
  int unsigned err_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned beats_seen = 0;
  int unsigned drops_seen = 0;
  int unsigned bursts_seen = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_en = 1'b1;
  bit          sink_stall_en = 1'b1;
  int unsigned sink_hold = 0;
  int unsigned sink_roll;

  serial_tx_rx_byte_queues_top #(
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt,
               pending_beats.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // output side backpressure: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin
    if (rst || !sink_stall_en) begin
      m_axis_tready <= 1'b1;
      sink_hold <= 0;
    end else if (sink_hold != 0) begin
      m_axis_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 20) begin
        m_axis_tready <= 1'b0;
        sink_hold <= (sink_roll < 3) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ring fill from a pointer pair, pointers wrap at twice the depth
  function automatic logic [FILL_W-1:0] ring_fill(logic [FILL_W-1:0] w, logic [FILL_W-1:0] r);
    return w - r;
  endfunction

  // queue one expected beat using the shadow state as it stands now
  function automatic void note_beat(kind_t k, logic [BYTE_W-1:0] d, logic lst, logic drop);
    uart_beat_t b;
    b.kind       = k;
    b.data       = d;
    b.last       = lst;
    b.dropped    = drop;
    b.rx_fill    = ring_fill(rx_wr, rx_rd);
    b.tx_fill    = ring_fill(tx_wr, tx_rd);
    b.modem      = modem_reg;
    b.modem_seen = modem_seen;
    b.line       = line_reg;
    b.line_seen  = line_seen;
    pending_beats.push_back(b);
  endfunction

  // pop up to limit bytes off the transmit ring, last flag on the final one
  function automatic void drain_tx(int unsigned limit);
    int unsigned n;
    logic [BYTE_W-1:0] v;
    n = 0;
    while (n < limit && ring_fill(tx_wr, tx_rd) != 0) begin
      v = tx_mem[tx_rd[SLOT_W-1:0]];
      tx_rd = tx_rd + 1'b1;
      note_beat(KIND_TX_BYTE, v, (n + 1 == limit) || (ring_fill(tx_wr, tx_rd) == 0), 1'b0);
      n++;
    end
    if (n == 0) note_beat(KIND_NOTHING, '0, 1'b1, 1'b0);
  endfunction

  // expected beats for one accepted input beat
  function automatic void predict_uart_op(logic [2:0] op, logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    case (op)
      OP_HOST_WRITE: begin
        if (ring_fill(tx_wr, tx_rd) >= DEPTH) begin
          note_beat(KIND_ACCEPTED, '0, 1'b1, 1'b1);
        end else begin
          tx_mem[tx_wr[SLOT_W-1:0]] = b;
          tx_wr = tx_wr + 1'b1;
          note_beat(KIND_ACCEPTED, '0, 1'b1, 1'b0);
        end
      end
      OP_HOST_READ: begin
        if (ring_fill(rx_wr, rx_rd) == 0) begin
          note_beat(KIND_READ_EMPTY, '0, 1'b1, 1'b0);
        end else begin
          v = rx_mem[rx_rd[SLOT_W-1:0]];
          rx_rd = rx_rd + 1'b1;
          note_beat(KIND_READ_DATA, v, 1'b1, 1'b0);
        end
      end
      OP_RX_BYTE: begin
        if (ring_fill(rx_wr, rx_rd) >= DEPTH) begin
          note_beat(KIND_ACCEPTED, '0, 1'b1, 1'b1);
        end else begin
          rx_mem[rx_wr[SLOT_W-1:0]] = b;
          rx_wr = rx_wr + 1'b1;
          note_beat(KIND_ACCEPTED, '0, 1'b1, 1'b0);
        end
      end
      OP_TX_READY: drain_tx(burst_mode ? BURST_LEN : 1);
      OP_KICK: drain_tx(1);
      OP_MODEM_STAT: begin
        modem_reg = b;
        modem_seen = 1'b1;
        note_beat(KIND_ACCEPTED, '0, 1'b1, 1'b0);
      end
      OP_LINE_STAT: begin
        line_reg = b;
        line_seen = 1'b1;
        note_beat(KIND_ACCEPTED, '0, 1'b1, 1'b0);
      end
      default: ;
    endcase
  endfunction

  // report a field mismatch, quiet after many so a broken block cannot flood the log
  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    uart_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      beats_seen++;
      if (m_axis_tdata[8]) drops_seen++;
      if (m_axis_tuser == KIND_TX_BYTE && m_axis_tlast && burst_mode) bursts_seen++;
      if (pending_beats.size() == 0) begin
        err_cnt++;
        $error("result beat with no expectation: kind %0d data 0x%0h",
               m_axis_tuser, m_axis_tdata[7:0]);
      end else begin
        want = pending_beats.pop_front();
        cmp_field("kind",             want.kind,       m_axis_tuser);
        cmp_field("data_out",         want.data,       m_axis_tdata[7:0]);
        cmp_field("last",             want.last,       m_axis_tlast);
        cmp_field("dropped",          want.dropped,    m_axis_tdata[8]);
        cmp_field("rx_fill",          want.rx_fill,    m_axis_tdata[20:9]);
        cmp_field("tx_fill",          want.tx_fill,    m_axis_tdata[32:21]);
        cmp_field("modem_stat_out",   want.modem,      m_axis_tdata[40:33]);
        cmp_field("modem_seen",       want.modem_seen, m_axis_tdata[41]);
        cmp_field("line_stat_out",    want.line,       m_axis_tdata[49:42]);
        cmp_field("line_seen",        want.line_seen,  m_axis_tdata[50]);
        cmp_field("tdata padding",    0,               m_axis_tdata[55:51]);
      end
    end
  end

  // sender gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // drive one input beat and wait for its handshake; valid stays high on return
  task automatic send_op(logic [2:0] op, logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_uart_op(op, b);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // stop sending until every expected beat is back, then let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // mode register write, only with the block idle
  task automatic set_mode(logic m);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    burst_mode = m;
  endtask

  // weighted op choice, mostly queue traffic
  function automatic logic [2:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return OP_HOST_WRITE;
    if (r < 40) return OP_HOST_READ;
    if (r < 60) return OP_RX_BYTE;
    if (r < 72) return OP_TX_READY;
    if (r < 80) return OP_KICK;
    if (r < 88) return OP_MODEM_STAT;
    if (r < 96) return OP_LINE_STAT;
    return OP_UNUSED;
  endfunction

  // empty queues right after reset, plus the unused op code
  task automatic test_empty_paths();
    send_op(OP_HOST_READ, 8'hFF);
    send_op(OP_TX_READY, 8'h00);
    send_op(OP_KICK, 8'hFF);
    send_op(OP_UNUSED, 8'hFF);
    send_op(OP_UNUSED, 8'h00);
  endtask

  // modem and line status capture with extreme bytes
  task automatic test_status_capture();
    send_op(OP_MODEM_STAT, 8'hFF);
    send_op(OP_LINE_STAT, 8'h00);
    send_op(OP_MODEM_STAT, 8'h00);
    send_op(OP_LINE_STAT, 8'hFF);
    send_op(OP_MODEM_STAT, 8'h5A);
  endtask

  // single bytes through both rings in both transmit modes
  task automatic test_single_byte_paths();
    send_op(OP_HOST_WRITE, 8'h00);
    send_op(OP_HOST_WRITE, 8'hFF);
    send_op(OP_HOST_WRITE, 8'hA5);
    send_op(OP_RX_BYTE, 8'hFF);
    send_op(OP_RX_BYTE, 8'h00);
    send_op(OP_HOST_READ, 8'h00);
    send_op(OP_HOST_READ, 8'h00);
    send_op(OP_HOST_READ, 8'h00);
    send_op(OP_KICK, 8'h00);
    send_op(OP_TX_READY, 8'h00);
    set_mode(1'b1);
    send_op(OP_TX_READY, 8'h00);
    send_op(OP_TX_READY, 8'h00);
  endtask

  // random traffic over four phases: mode alternates, no send gaps in phase 2, no sink stalls in phase 1
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned cnt;
    bit paused;
    logic [2:0] op;
    for (phase = 0; phase < 4; phase++) begin
      set_mode(phase[0]);
      idle_en = (phase != 2);
      sink_stall_en = (phase != 1);
      cnt = 0;
      paused = 1'b0;
      while (cnt < RAND_PER_PHASE) begin
        op = pick_op();
        send_op(op, 8'($urandom_range(0, 255)));
        if (op != OP_UNUSED) cnt++;
        if (cnt == RAND_PER_PHASE / 2 && !paused) begin
          settle();
          paused = 1'b1;
        end
      end
    end
    idle_en = 1'b1;
    sink_stall_en = 1'b1;
  endtask

  // test sequence
  initial begin : main_seq
    int unsigned waited;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_paths();
    test_status_capture();
    test_single_byte_paths();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_beats.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYC) @(posedge clk);
    if (pending_beats.size() != 0) begin
      err_cnt++;
      $error("%0d expected result beats never arrived", pending_beats.size());
    end
    $display("covered %0d input beats and %0d result beats (%0d drops, %0d burst ends),",
             items_sent, beats_seen, drops_seen, bursts_seen);
    $display("empty rings, status capture and mixed traffic in both transmit modes");
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
